[hdl/tss_pkg.sv]
// shared types, codes and structs for the triggered sampling sequencer
package tss_pkg;

    typedef enum logic [1:0] {
        ST_STOPPED  = 2'd0,
        ST_STARTING = 2'd1,
        ST_WAITLOCK = 2'd2,
        ST_RUNNING  = 2'd3
    } t_seq_st;

    localparam logic [1:0] OP_TRIGGER    = 2'd0;
    localparam logic [1:0] OP_START_REQ  = 2'd1;
    localparam logic [1:0] OP_STOP_REQ   = 2'd2;

    localparam logic [1:0] TRIG_NORMAL   = 2'd0;
    localparam logic [1:0] TRIG_OVERRUN  = 2'd1;
    localparam logic [1:0] TRIG_TIMEOUT  = 2'd2;

    localparam logic [2:0] RSN_NONE        = 3'd0;
    localparam logic [2:0] RSN_REQ_STOP    = 3'd1;
    localparam logic [2:0] RSN_TIMEOUT     = 3'd2;
    localparam logic [2:0] RSN_PLL_LOST    = 3'd3;
    localparam logic [2:0] RSN_SAMPLE_FAIL = 3'd4;

    localparam logic [1:0] ERR_OK            = 2'd0;
    localparam logic [1:0] ERR_NOT_STOPPED   = 2'd1;
    localparam logic [1:0] ERR_REQ_PENDING   = 2'd2;
    localparam logic [1:0] ERR_STOP_PENDING  = 2'd3;

    typedef struct packed {
        t_seq_st     seq_state;
        logic        start_pending;
        logic        stop_pending;
        logic [7:0]  delay_count;
    } t_ctx;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  trigger_outcome;
        logic        pll_locked;
        logic        sample_ok;
        logic [7:0]  start_delay;
    } t_item;

    typedef struct packed {
        logic [1:0]  state_now;
        logic        notify;
        logic [2:0]  notify_reason;
        logic        sample_strobe;
        logic        sample_overrun;
        logic        start_strobe;
        logic        stop_strobe;
        logic [1:0]  request_error;
    } t_result;

endpackage

[hdl/tss_step.sv]
// next-state and result logic for one beat of the sequencer
module tss_step (
    input  tss_pkg::t_ctx    i_ctx,
    input  tss_pkg::t_item   i_item,
    input  logic             i_pll_monitor_enable,
    output tss_pkg::t_ctx    o_ctx,
    output tss_pkg::t_result o_result
);

    logic    timeout;
    logic    overrun;
    logic    lock_ok;
    tss_pkg::t_ctx    nxt;
    tss_pkg::t_result res;

    assign timeout = (i_item.trigger_outcome == tss_pkg::TRIG_TIMEOUT);
    assign overrun = (i_item.trigger_outcome == tss_pkg::TRIG_OVERRUN);
    assign lock_ok = !i_pll_monitor_enable || i_item.pll_locked;

    always_comb begin
        nxt = i_ctx;
        res = '0;
        unique case (i_item.operation)
            tss_pkg::OP_TRIGGER: begin
                unique case (i_ctx.seq_state)
                    tss_pkg::ST_STOPPED: begin
                        if (i_ctx.stop_pending) begin
                            nxt.stop_pending  = 1'b0;
                            res.notify        = 1'b1;
                            res.notify_reason = tss_pkg::RSN_REQ_STOP;
                        end else if (i_ctx.start_pending) begin
                            nxt.start_pending = 1'b0;
                            nxt.seq_state     = tss_pkg::ST_STARTING;
                            res.notify        = 1'b1;
                        end
                    end
                    tss_pkg::ST_STARTING: begin
                        if (i_ctx.stop_pending) begin
                            nxt.stop_pending  = 1'b0;
                            nxt.seq_state     = tss_pkg::ST_STOPPED;
                            res.notify        = 1'b1;
                            res.notify_reason = tss_pkg::RSN_REQ_STOP;
                        end else if (i_ctx.delay_count == 8'd0) begin
                            nxt.seq_state     = tss_pkg::ST_WAITLOCK;
                            res.notify        = 1'b1;
                        end else begin
                            nxt.delay_count   = i_ctx.delay_count - 8'd1;
                        end
                    end
                    tss_pkg::ST_WAITLOCK: begin
                        if (timeout) begin
                            nxt.seq_state     = tss_pkg::ST_STOPPED;
                            res.notify        = 1'b1;
                            res.notify_reason = tss_pkg::RSN_TIMEOUT;
                        end else if (i_ctx.stop_pending) begin
                            nxt.stop_pending  = 1'b0;
                            nxt.seq_state     = tss_pkg::ST_STOPPED;
                            res.notify        = 1'b1;
                            res.notify_reason = tss_pkg::RSN_REQ_STOP;
                        end else if (lock_ok) begin
                            nxt.seq_state     = tss_pkg::ST_RUNNING;
                            res.notify        = 1'b1;
                            res.start_strobe  = 1'b1;
                        end
                    end
                    tss_pkg::ST_RUNNING: begin
                        priority if (timeout) begin
                            nxt.seq_state     = tss_pkg::ST_STOPPED;
                            res.stop_strobe   = 1'b1;
                            res.notify        = 1'b1;
                            res.notify_reason = tss_pkg::RSN_TIMEOUT;
                        end else if (!lock_ok) begin
                            nxt.seq_state     = tss_pkg::ST_STOPPED;
                            res.stop_strobe   = 1'b1;
                            res.notify        = 1'b1;
                            res.notify_reason = tss_pkg::RSN_PLL_LOST;
                        end else if (i_ctx.stop_pending) begin
                            nxt.stop_pending  = 1'b0;
                            nxt.seq_state     = tss_pkg::ST_STOPPED;
                            res.stop_strobe   = 1'b1;
                            res.notify        = 1'b1;
                            res.notify_reason = tss_pkg::RSN_REQ_STOP;
                        end else begin
                            res.sample_strobe  = 1'b1;
                            res.sample_overrun = overrun;
                            if (!i_item.sample_ok) begin
                                nxt.seq_state     = tss_pkg::ST_STOPPED;
                                res.stop_strobe   = 1'b1;
                                res.notify        = 1'b1;
                                res.notify_reason = tss_pkg::RSN_SAMPLE_FAIL;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            tss_pkg::OP_START_REQ: begin
                if (i_ctx.seq_state != tss_pkg::ST_STOPPED) begin
                    res.request_error = tss_pkg::ERR_NOT_STOPPED;
                end else if (i_ctx.start_pending || i_ctx.stop_pending) begin
                    res.request_error = tss_pkg::ERR_REQ_PENDING;
                end else begin
                    nxt.start_pending = 1'b1;
                    nxt.delay_count   = i_item.start_delay;
                end
            end
            tss_pkg::OP_STOP_REQ: begin
                if (i_ctx.stop_pending) begin
                    res.request_error = tss_pkg::ERR_STOP_PENDING;
                end else begin
                    nxt.stop_pending  = 1'b1;
                    nxt.start_pending = 1'b0;
                end
            end
            default: begin
            end
        endcase
        res.state_now = nxt.seq_state;
    end

    assign o_ctx    = nxt;
    assign o_result = res;

endmodule

[hdl/triggered_sampling_sequencer.sv]
// top level: input register, step logic, sequencer state and result register
//
//  channel  direction  handshake                payload
//  in       sink       i_in_valid / o_in_stall  i_operation .. i_start_delay
//  out      source     o_out_valid / i_out_stall o_state_now .. o_request_error
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_data (pll monitor enable)
//
// input beat to result beat passes the input register, then the result register
// one beat per cycle while the output is not stalled; the sequencer state updates
// as a beat moves into the result register, so the next beat in the input register sees it
// synchronous active-low reset clears state, config and both valid flags
// a stalled result holds both stages; the input stall follows the output stall
module triggered_sampling_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_operation,
    input  logic [1:0] i_trigger_outcome,
    input  logic       i_pll_locked,
    input  logic       i_sample_ok,
    input  logic [7:0] i_start_delay,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_state_now,
    output logic       o_notify,
    output logic [2:0] o_notify_reason,
    output logic       o_sample_strobe,
    output logic       o_sample_overrun,
    output logic       o_start_strobe,
    output logic       o_stop_strobe,
    output logic [1:0] o_request_error,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);

    logic             r_in_valid;
    tss_pkg::t_item   r_item;
    logic             r_out_valid;
    tss_pkg::t_result r_result;
    tss_pkg::t_ctx    r_ctx;
    logic             r_pll_mon;

    tss_pkg::t_ctx    n_ctx;
    tss_pkg::t_result n_result;
    logic             advance;
    logic             in_take;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = !r_in_valid;

    tss_step u_step (
        .i_ctx                (r_ctx),
        .i_item               (r_item),
        .i_pll_monitor_enable (r_pll_mon),
        .o_ctx                (n_ctx),
        .o_result             (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pll_mon   <= 1'b0;
            r_ctx       <= '{seq_state: tss_pkg::ST_STOPPED, start_pending: 1'b0,
                             stop_pending: 1'b0, delay_count: 8'd0};
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ctx       <= n_ctx;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_pll_mon <= i_cfg_data;
            end
        end
    end

    // payload beats
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= '{operation: i_operation, trigger_outcome: i_trigger_outcome,
                        pll_locked: i_pll_locked, sample_ok: i_sample_ok,
                        start_delay: i_start_delay};
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_state_now      = r_result.state_now;
    assign o_notify         = r_result.notify;
    assign o_notify_reason  = r_result.notify_reason;
    assign o_sample_strobe  = r_result.sample_strobe;
    assign o_sample_overrun = r_result.sample_overrun;
    assign o_start_strobe   = r_result.start_strobe;
    assign o_stop_strobe    = r_result.stop_strobe;
    assign o_request_error  = r_result.request_error;

`ifndef NO_ASSERTIONS
    a_reason_needs_notify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.notify_reason != tss_pkg::RSN_NONE) |-> r_result.notify)
        else $error("stop reason without notice");

    a_start_in_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.start_strobe) |->
        (r_result.state_now == tss_pkg::ST_RUNNING && r_result.notify))
        else $error("start strobe outside running entry");

    a_stop_to_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.stop_strobe) |->
        (r_result.state_now == tss_pkg::ST_STOPPED && r_result.notify &&
         r_ctx.seq_state == tss_pkg::ST_STOPPED))
        else $error("stop strobe without stopped state");

    a_error_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_result.request_error != tss_pkg::ERR_OK) |=>
        ($stable(r_ctx) && !r_result.notify))
        else $error("rejected request changed state");
`endif

endmodule
